FILE: sv/dqs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqs_pkg
// Types and codes shared by the deque-with-search block, its channels and
// its checker.
// ----------------------------------------------------------------------------
package dqs_pkg;

  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;
  localparam int DATA_W = 32;
  localparam int POS_W  = 4;
  localparam int OCC_W  = 5;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [DATA_W-1:0] data_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [OCC_W-1:0]  occ_t;

  localparam cmd_t CMD_PUSH_FRONT = 3'd0;
  localparam cmd_t CMD_PUSH_BACK  = 3'd1;
  localparam cmd_t CMD_POP_FRONT  = 3'd2;
  localparam cmd_t CMD_POP_BACK   = 3'd3;
  localparam cmd_t CMD_REMOVE     = 3'd4;
  localparam cmd_t CMD_FIND       = 3'd5;

  localparam status_t STAT_DONE      = 2'd0;
  localparam status_t STAT_EMPTY     = 2'd1;
  localparam status_t STAT_NOT_FOUND = 2'd2;
  localparam status_t STAT_FULL      = 2'd3;

endpackage

FILE: sv/dqs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqs_if
// Valid/ready channels: command transactions in, result transactions out.
// ----------------------------------------------------------------------------
interface dqs_in_if;
  import dqs_pkg::*;

  logic               valid;
  logic               ready;
  cmd_t               command;
  logic signed [31:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface dqs_out_if;
  import dqs_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  pos_t    position;
  occ_t    occupancy;

  modport source (output valid, output status, output position, output occupancy, input ready);
  modport sink   (input valid, input status, input position, input occupancy, output ready);
endinterface

FILE: sv/dqs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/deque_with_value_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_value_search
// Bounded double-ended queue of 32-bit values held in a circular RAM, with
// find and remove-first-match run by a small sequencer over one address unit.
// ----------------------------------------------------------------------------
// Push and pop: the result is valid in the cycle after the transaction is taken.
// Find: each entry examined takes a RAM read state, then a compare state, over at most DEPTH entries.
// Remove: as find, then each entry behind the match is moved up by a read state and a write state.
// One command in flight; ready is low while a search or compaction runs.
// Synchronous reset empties the queue; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module deque_with_value_search #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  dqs_in_if.sink      req,
  dqs_out_if.source   rsp
);
  import dqs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SRCH_RD  = 3'd1;
  localparam logic [2:0] ST_SRCH_CMP = 3'd2;
  localparam logic [2:0] ST_SHIFT_RD = 3'd3;
  localparam logic [2:0] ST_SHIFT_WR = 3'd4;

  logic [2:0]    state;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [AW-1:0] idx;
  data_t         key;
  logic          is_remove;

  logic          rsp_valid;
  status_t       rsp_status;
  pos_t          rsp_position;
  occ_t          rsp_occupancy;

  logic          accept;
  logic          full;
  logic          empty;
  logic [AW-1:0] idx_inc;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] lidx;
  logic [AW:0]   sum;
  logic [AW-1:0] phys;
  logic [CW:0]   idx_p1;
  logic [CW:0]   idx_p2;
  logic          last_srch;
  logic          last_shift;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] count_dec;

  logic          we;
  logic [AW-1:0] waddr;
  data_t         wdata;
  data_t         rd_data;

  assign req.ready     = (state == ST_IDLE) && (!rsp_valid || rsp.ready);
  assign accept        = req.valid && req.ready;
  assign rsp.valid     = rsp_valid;
  assign rsp.status    = rsp_status;
  assign rsp.position  = rsp_position;
  assign rsp.occupancy = rsp_occupancy;

  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign count_inc = count + CW'(1);
  assign count_dec = count - CW'(1);
  assign idx_inc   = idx + AW'(1);
  assign head_inc  = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
  assign head_dec  = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);

  assign idx_p1     = (CW + 1)'(idx) + (CW + 1)'(1);
  assign idx_p2     = (CW + 1)'(idx) + (CW + 1)'(2);
  assign last_srch  = (idx_p1 >= (CW + 1)'(count));
  assign last_shift = (idx_p2 >= (CW + 1)'(count));

  // shared logical-to-physical address unit
  always_comb begin
    case (state)
      ST_IDLE:     lidx = AW'(count);
      ST_SHIFT_RD: lidx = idx_inc;
      default:     lidx = idx;
    endcase
  end

  assign sum  = {1'b0, head} + {1'b0, lidx};
  assign phys = (sum >= (AW + 1)'(DEPTH)) ? AW'(sum - (AW + 1)'(DEPTH)) : sum[AW-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = phys;
    wdata = data_t'(req.value);
    if (state == ST_IDLE) begin
      if (accept && !full) begin
        if (req.command == CMD_PUSH_FRONT) begin
          we    = 1'b1;
          waddr = head_dec;
        end else if (req.command == CMD_PUSH_BACK) begin
          we = 1'b1;
        end
      end
    end else if (state == ST_SHIFT_WR) begin
      we    = 1'b1;
      wdata = rd_data;
    end
  end

  dqs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (phys),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            key          <= data_t'(req.value);
            is_remove    <= (req.command == CMD_REMOVE);
            idx          <= '0;
            rsp_position <= '0;
            case (req.command)
              CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                rsp_valid <= 1'b1;
                if (full) begin
                  rsp_status    <= STAT_FULL;
                  rsp_occupancy <= OCC_W'(count);
                end else begin
                  if (req.command == CMD_PUSH_FRONT) begin
                    head <= head_dec;
                  end
                  count         <= count_inc;
                  rsp_status    <= STAT_DONE;
                  rsp_occupancy <= OCC_W'(count_inc);
                end
              end
              CMD_POP_FRONT, CMD_POP_BACK: begin
                rsp_valid <= 1'b1;
                if (empty) begin
                  rsp_status    <= STAT_EMPTY;
                  rsp_occupancy <= OCC_W'(count);
                end else begin
                  if (req.command == CMD_POP_FRONT) begin
                    head <= head_inc;
                  end
                  count         <= count_dec;
                  rsp_status    <= STAT_DONE;
                  rsp_occupancy <= OCC_W'(count_dec);
                end
              end
              CMD_REMOVE, CMD_FIND: begin
                if (empty) begin
                  rsp_valid     <= 1'b1;
                  rsp_status    <= STAT_EMPTY;
                  rsp_occupancy <= OCC_W'(count);
                end else begin
                  state <= ST_SRCH_RD;
                end
              end
              default: begin
                rsp_valid     <= 1'b1;
                rsp_status    <= STAT_DONE;
                rsp_occupancy <= OCC_W'(count);
              end
            endcase
          end
        end
        ST_SRCH_RD: begin
          state <= ST_SRCH_CMP;
        end
        ST_SRCH_CMP: begin
          if (rd_data == key) begin
            rsp_position <= POS_W'(idx);
            if (!is_remove) begin
              state         <= ST_IDLE;
              rsp_valid     <= 1'b1;
              rsp_status    <= STAT_DONE;
              rsp_occupancy <= OCC_W'(count);
            end else if (last_srch) begin
              state         <= ST_IDLE;
              count         <= count_dec;
              rsp_valid     <= 1'b1;
              rsp_status    <= STAT_DONE;
              rsp_occupancy <= OCC_W'(count_dec);
            end else begin
              state <= ST_SHIFT_RD;
            end
          end else if (last_srch) begin
            state         <= ST_IDLE;
            rsp_valid     <= 1'b1;
            rsp_status    <= STAT_NOT_FOUND;
            rsp_occupancy <= OCC_W'(count);
          end else begin
            idx   <= idx_inc;
            state <= ST_SRCH_RD;
          end
        end
        ST_SHIFT_RD: begin
          state <= ST_SHIFT_WR;
        end
        ST_SHIFT_WR: begin
          idx <= idx_inc;
          if (last_shift) begin
            state         <= ST_IDLE;
            count         <= count_dec;
            rsp_valid     <= 1'b1;
            rsp_status    <= STAT_DONE;
            rsp_occupancy <= OCC_W'(count_dec);
          end else begin
            state <= ST_SHIFT_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/dqs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqs_checker
// Port-level checks on the deque block, bound to its top level.
// ----------------------------------------------------------------------------
module dqs_checker (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input dqs_pkg::status_t rsp_status,
  input dqs_pkg::pos_t    rsp_position,
  input dqs_pkg::occ_t    rsp_occupancy
);
  import dqs_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_occupancy))
    else $error("stalled result changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && rsp_valid |-> rsp_ready)
    else $error("transaction taken while result slot stays full");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == STAT_EMPTY |-> rsp_occupancy == '0)
    else $error("empty status with nonzero occupancy");

  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != STAT_DONE |-> rsp_position == '0)
    else $error("position set on failed command");

endmodule

bind deque_with_value_search dqs_checker u_dqs_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_status    (rsp.status),
  .rsp_position  (rsp.position),
  .rsp_occupancy (rsp.occupancy)
);

FILE: dv/deque_with_value_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_value_search_tb
// Drives command transactions into the deque and checks every result
// transaction against a queue-based predictor. It covers empty and full
// queues, value extremes, find and remove hits and misses, and unused
// command codes. Random traffic runs under several idle and stall mixes.
// ----------------------------------------------------------------------------
module deque_with_value_search_tb;
  import dqs_pkg::*;

  localparam int DEPTH        = 16;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 80;

  localparam cmd_t CMD_RSVD_LO = 3'd6;
  localparam cmd_t CMD_RSVD_HI = 3'd7;

  typedef struct packed {
    status_t status;
    pos_t    position;
    occ_t    occupancy;
  } dq_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dqs_in_if  req_if ();
  dqs_out_if rsp_if ();

  deque_with_value_search #(.DEPTH(DEPTH)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  data_t      deque_model[$];
  dq_result_t expected_results[$];

  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  int errors        = 0;
  int n_sent        = 0;
  int n_checked     = 0;
  int n_full        = 0;
  int n_empty       = 0;
  int n_miss        = 0;
  int peak_fill     = 0;
  int idle_cycles   = 0;
  bit fill_mode     = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one command to the model deque and returns its result.
  function automatic dq_result_t apply_deque_cmd(input cmd_t c, input data_t v);
    dq_result_t r;
    int         hit;
    r.status   = STAT_DONE;
    r.position = '0;
    hit        = -1;
    case (c)
      CMD_PUSH_FRONT: begin
        if (deque_model.size() >= DEPTH) r.status = STAT_FULL;
        else deque_model.push_front(v);
      end
      CMD_PUSH_BACK: begin
        if (deque_model.size() >= DEPTH) r.status = STAT_FULL;
        else deque_model.push_back(v);
      end
      CMD_POP_FRONT: begin
        if (deque_model.size() == 0) r.status = STAT_EMPTY;
        else void'(deque_model.pop_front());
      end
      CMD_POP_BACK: begin
        if (deque_model.size() == 0) r.status = STAT_EMPTY;
        else void'(deque_model.pop_back());
      end
      CMD_REMOVE, CMD_FIND: begin
        if (deque_model.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          for (int i = 0; i < deque_model.size(); i++)
            if (hit < 0 && deque_model[i] == v) hit = i;
          if (hit < 0) begin
            r.status = STAT_NOT_FOUND;
          end else begin
            r.position = pos_t'(hit);
            if (c == CMD_REMOVE) deque_model.delete(hit);
          end
        end
      end
      default: ;
    endcase
    r.occupancy = occ_t'(deque_model.size());
    return r;
  endfunction

  // Mix of held values, a small pool with repeats, and full-range values.
  function automatic data_t pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40 && deque_model.size() > 0)
      return deque_model[$urandom_range(deque_model.size() - 1)];
    if (sel < 70) return data_t'($urandom_range(7)) - data_t'(4);
    return data_t'($urandom);
  endfunction

  task automatic send_cmd(input cmd_t c, input data_t v);
    req_if.valid   <= 1'b1;
    req_if.command <= c;
    req_if.value   <= v;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    expected_results.push_back(apply_deque_cmd(c, v));
    n_sent++;
    if (deque_model.size() > peak_fill) peak_fill = deque_model.size();
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic test_empty_queue();
    send_cmd(CMD_POP_FRONT, 32'h0000_0001);
    send_cmd(CMD_POP_BACK, 32'hFFFF_FFFF);
    send_cmd(CMD_REMOVE, 32'h0000_0000);
    send_cmd(CMD_FIND, 32'h0000_0000);
    send_cmd(CMD_RSVD_LO, 32'h1234_5678);
    send_cmd(CMD_RSVD_HI, 32'hFFFF_FFFF);
  endtask

  task automatic test_value_extremes();
    send_cmd(CMD_PUSH_BACK, 32'h7FFF_FFFF);
    send_cmd(CMD_PUSH_FRONT, 32'h8000_0000);
    send_cmd(CMD_PUSH_BACK, 32'h0000_0000);
    send_cmd(CMD_PUSH_BACK, 32'hFFFF_FFFF);
    send_cmd(CMD_FIND, 32'h8000_0000);
    send_cmd(CMD_FIND, 32'hFFFF_FFFF);
    send_cmd(CMD_FIND, 32'h0000_0001);
    send_cmd(CMD_REMOVE, 32'h7FFF_FFFE);
    send_cmd(CMD_REMOVE, 32'h0000_0000);
    send_cmd(CMD_RSVD_LO, 32'h0000_0000);
    send_cmd(CMD_FIND, 32'hFFFF_FFFF);
    send_cmd(CMD_POP_FRONT, 32'h0000_0000);
    send_cmd(CMD_POP_BACK, 32'h0000_0000);
    send_cmd(CMD_POP_BACK, 32'h0000_0000);
    send_cmd(CMD_POP_FRONT, 32'h0000_0000);
  endtask

  task automatic test_fill_to_full();
    while (deque_model.size() < DEPTH - 1)
      send_cmd($urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_value());
    send_cmd(CMD_PUSH_BACK, 32'h0000_1000);
    send_cmd(CMD_PUSH_FRONT, 32'h5A5A_5A5A);
    send_cmd(CMD_PUSH_BACK, 32'hA5A5_A5A5);
    send_cmd(CMD_FIND, 32'h0000_1000);
    send_cmd(CMD_REMOVE, 32'h0000_1000);
    send_cmd(CMD_PUSH_BACK, 32'h0000_1000);
    send_cmd(CMD_REMOVE, deque_model[0]);
    send_cmd(CMD_FIND, 32'h0000_2000);
    wait_for_results();
  endtask

  task automatic run_random_traffic(input int n_items, input int idle_pct,
                                    input int stall_pct);
    cmd_t c;
    int   r;
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    repeat (n_items) begin
      if ($urandom_range(39) == 0) fill_mode = !fill_mode;
      r = $urandom_range(99);
      if (r < (fill_mode ? 50 : 15))
        c = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      else if (r < 62)
        c = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
      else if (r < 79)
        c = CMD_REMOVE;
      else if (r < 96)
        c = CMD_FIND;
      else
        c = $urandom_range(1) ? CMD_RSVD_HI : CMD_RSVD_LO;
      send_cmd(c, pick_value());
      if ($urandom_range(49) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  always @(posedge clk) begin
    rsp_if.ready <= !rst && ($urandom_range(99) >= rsp_stall_pct);
  end

  always @(posedge clk) begin : check_results
    dq_result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      n_checked++;
      if (rsp_if.status == STAT_FULL) n_full++;
      if (rsp_if.status == STAT_EMPTY) n_empty++;
      if (rsp_if.status == STAT_NOT_FOUND) n_miss++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got status %0d position %0d occupancy %0d",
                 $time, rsp_if.status, rsp_if.position, rsp_if.occupancy);
      end else begin
        want = expected_results.pop_front();
        if (rsp_if.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, want.status, rsp_if.status);
        end
        if (rsp_if.position !== want.position) begin
          errors++;
          $display("%0t: position expected %0d got %0d",
                   $time, want.position, rsp_if.position);
        end
        if (rsp_if.occupancy !== want.occupancy) begin
          errors++;
          $display("%0t: occupancy expected %0d got %0d",
                   $time, want.occupancy, rsp_if.occupancy);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("deque_with_value_search: mismatch");
      $finish;
    end
  end

  initial begin
    req_if.valid   <= 1'b0;
    req_if.command <= CMD_PUSH_FRONT;
    req_if.value   <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_value_extremes();
    test_fill_to_full();
    run_random_traffic(130, 0, 0);
    run_random_traffic(130, 62, 0);
    run_random_traffic(130, 0, 62);
    run_random_traffic(130, 23, 23);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d commands over four idle/stall mixes, checked %0d results, peak fill %0d",
             n_sent, n_checked, peak_fill);
    $display("status seen: full %0d, empty %0d, not found %0d", n_full, n_empty, n_miss);
    if (errors == 0 && expected_results.size() == 0)
      $display("deque_with_value_search: match");
    else
      $display("deque_with_value_search: mismatch");
    $finish;
  end

endmodule
